/* src/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/rrts_pkg.sv */
// Package for the round-robin thread scheduler: sizes, codes and types.
// Used by every module of the RTL and testbench; depends on nothing.
package rrts_pkg;

    localparam int THREADS  = 16;
    localparam int CORES    = 4;
    localparam int THREAD_W = $clog2(THREADS);
    localparam int CORE_W   = $clog2(CORES);
    localparam int CNT_W    = $clog2(THREADS + 1);

    typedef enum logic [2:0] {
        F_TICK  = 3'd0,
        F_PAUSE = 3'd1,
        F_WAKE  = 3'd2,
        F_ADMIT = 3'd3,
        F_EXIT  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_ABSENT  = 2'd0,
        SL_READY   = 2'd1,
        SL_RUNNING = 2'd2,
        SL_WAITING = 2'd3
    } t_slot;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_PUSH   = 2'd1,
        Q_REMOVE = 2'd2
    } t_qop;

    typedef struct packed {
        t_qop                op;
        logic [THREAD_W-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_q_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_WPUSH,
        S_POP,
        S_XFIN,
        S_RESP
    } t_state;

endpackage

/* src/rrts_cell.sv */
// One entry of the ready queue, kept as a row of cells that shift left on removal.
// Depends on rrts_pkg.
module rrts_cell import rrts_pkg::*; (
    input  logic                i_clk,
    input  t_q_cmd              i_cmd,
    input  logic [THREAD_W-1:0] i_idx,
    input  logic [THREAD_W-1:0] i_right_val,
    input  logic                i_hit,
    output logic                o_hit,
    output logic [THREAD_W-1:0] o_val
);

    logic [THREAD_W-1:0] r_val;
    logic                w_valid;
    logic                w_match;

    assign w_valid = {1'b0, i_idx} < i_cmd.count;
    assign w_match = w_valid && (r_val == i_cmd.key) && (i_cmd.op == Q_REMOVE);
    assign o_hit   = i_hit | w_match;
    assign o_val   = r_val;

    // Once the removed entry is found, every cell from there on takes its right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == Q_PUSH && {1'b0, i_idx} == i_cmd.count) begin
            r_val <= i_cmd.key;
        end else if (i_cmd.op == Q_REMOVE && o_hit) begin
            r_val <= i_right_val;
        end
    end

endmodule

/* src/round_robin_thread_scheduler.sv */
// Top level of the round-robin thread scheduler: control sequencer, slot states,
// per-core registers and the ready queue cell row. Depends on rrts_pkg, rrts_cell.
//
// Usage: a request beat (func, core, thread) enters on i_in_valid while o_in_stall
// is low. One result beat (status, running thread, running valid, ready count)
// leaves on o_out_valid and is taken when i_out_stall is low.
// One request is handled at a time by a small sequencer; each step does at most
// one queue operation in the cell row (push at the tail or remove one entry with
// a left shift), one slot-state read and at most one write. After the check step,
// pause and any request turned back there go straight to the result step; admit
// and wake pass a write-and-push step, tick a pop step, and exit a pop step and,
// when a thread was popped, a finishing step. The next request is accepted from
// the cycle after its result is registered.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished request waits in its last step until the register is free.
// Reset (synchronous, active low) marks all slots absent, empties the queue
// and clears every core; no clearing pass is needed.
module round_robin_thread_scheduler import rrts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_func,
    input  logic [CORE_W-1:0]   i_core,
    input  logic [THREAD_W-1:0] i_thread,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [THREAD_W-1:0] o_running_thread,
    output logic                o_running_valid,
    output logic [CNT_W-1:0]    o_ready_count
);

`include "assert_macros.svh"

    t_state              r_state, n_state;
    logic [2:0]          r_func;
    logic [CORE_W-1:0]   r_core;
    logic [THREAD_W-1:0] r_thread;
    logic [THREAD_W-1:0] r_prev, n_prev;
    t_status             r_stat, n_stat;
    logic                r_exit, n_exit;
    logic [CNT_W-1:0]    r_count, n_count;

    t_slot               r_slot [THREADS];
    logic [THREAD_W-1:0] r_cthread [CORES];
    logic [CORES-1:0]    r_busy;

    // One slot-state read port and one write port.
    logic [THREAD_W-1:0] w_raddr;
    t_slot               w_rdata;
    logic                w_we;
    logic [THREAD_W-1:0] w_waddr;
    t_slot               w_wdata;

    logic                w_core_we;
    logic [THREAD_W-1:0] w_core_thread;
    logic                w_core_busy;

    t_q_cmd              w_cmd;
    logic [THREAD_W-1:0] w_val [THREADS];
    logic [THREADS:0]    w_hit;

    logic                w_load;

    assign w_rdata    = r_slot[w_raddr];
    assign o_in_stall = (r_state != S_IDLE);

    genvar gi;
    generate
        for (gi = 0; gi < THREADS; gi++) begin : g_cell
            rrts_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_idx       (THREAD_W'(gi)),
                .i_right_val ((gi == THREADS - 1) ? w_val[gi] : w_val[(gi + 1) % THREADS]),
                .i_hit       (w_hit[gi]),
                .o_hit       (w_hit[gi + 1]),
                .o_val       (w_val[gi])
            );
        end
    endgenerate
    assign w_hit[0] = 1'b0;

    always_comb begin
        n_state       = r_state;
        n_prev        = r_prev;
        n_stat        = r_stat;
        n_exit        = r_exit;
        n_count       = r_count;
        w_raddr       = r_prev;
        w_we          = 1'b0;
        w_waddr       = r_prev;
        w_wdata       = SL_ABSENT;
        w_core_we     = 1'b0;
        w_core_thread = r_cthread[r_core];
        w_core_busy   = r_busy[r_core];
        w_cmd.op      = Q_NONE;
        w_cmd.key     = r_thread;
        w_cmd.count   = r_count;
        w_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_prev = r_cthread[r_core];
                n_exit = 1'b0;
                n_stat = ST_OK;
                if (r_func == F_WAKE || r_func == F_ADMIT) begin
                    w_raddr = r_thread;
                end else begin
                    w_raddr = r_cthread[r_core];
                end
                n_state = S_RESP;
                case (r_func)
                    F_TICK, F_EXIT: begin
                        if (r_func == F_EXIT && !r_busy[r_core]) begin
                            n_stat = ST_INVALID;
                        end else if (r_func == F_EXIT && w_rdata == SL_ABSENT) begin
                            n_stat = ST_ABSENT;
                        end else begin
                            n_exit  = (r_func == F_EXIT);
                            n_state = S_POP;
                            if (r_busy[r_core] && w_rdata == SL_RUNNING) begin
                                w_we    = 1'b1;
                                w_waddr = r_cthread[r_core];
                                w_wdata = SL_READY;
                                if (r_count < CNT_W'(THREADS)) begin
                                    w_cmd.op  = Q_PUSH;
                                    w_cmd.key = r_cthread[r_core];
                                    n_count   = r_count + 1'b1;
                                end
                            end
                        end
                    end
                    F_PAUSE: begin
                        if (r_busy[r_core] && w_rdata == SL_RUNNING) begin
                            w_we    = 1'b1;
                            w_waddr = r_cthread[r_core];
                            w_wdata = SL_WAITING;
                        end else begin
                            n_stat = ST_INVALID;
                        end
                    end
                    F_WAKE: begin
                        if (w_rdata == SL_ABSENT) begin
                            n_stat = ST_ABSENT;
                        end else begin
                            n_state = S_WPUSH;
                            if (w_rdata == SL_READY) begin
                                w_cmd.op = Q_REMOVE;
                                n_count  = r_count - CNT_W'(w_hit[THREADS]);
                            end
                        end
                    end
                    F_ADMIT: begin
                        if (w_rdata != SL_ABSENT) begin
                            n_stat = ST_INVALID;
                        end else begin
                            n_state = S_WPUSH;
                        end
                    end
                    default: begin
                        n_stat = ST_INVALID;
                    end
                endcase
            end
            S_WPUSH: begin
                w_we    = 1'b1;
                w_waddr = r_thread;
                w_wdata = SL_READY;
                if (r_count < CNT_W'(THREADS)) begin
                    w_cmd.op = Q_PUSH;
                    n_count  = r_count + 1'b1;
                end
                n_state = S_RESP;
            end
            S_POP: begin
                if (r_count == '0) begin
                    n_stat  = ST_EMPTY;
                    n_state = S_RESP;
                end else begin
                    w_cmd.op      = Q_REMOVE;
                    w_cmd.key     = w_val[0];
                    n_count       = r_count - 1'b1;
                    w_we          = 1'b1;
                    w_waddr       = w_val[0];
                    w_wdata       = SL_RUNNING;
                    w_core_we     = 1'b1;
                    w_core_thread = w_val[0];
                    w_core_busy   = 1'b1;
                    n_state       = r_exit ? S_XFIN : S_RESP;
                end
            end
            S_XFIN: begin
                w_raddr = r_prev;
                if (w_rdata == SL_READY) begin
                    w_cmd.op  = Q_REMOVE;
                    w_cmd.key = r_prev;
                    n_count   = r_count - CNT_W'(w_hit[THREADS]);
                end
                if (r_cthread[r_core] == r_prev) begin
                    w_core_we   = 1'b1;
                    w_core_busy = 1'b0;
                end
                w_we    = 1'b1;
                w_waddr = r_prev;
                w_wdata = SL_ABSENT;
                n_state = S_RESP;
            end
            S_RESP: begin
                w_raddr = r_cthread[r_core];
                if (!o_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_busy  <= '0;
            for (int i = 0; i < THREADS; i++) begin
                r_slot[i] <= SL_ABSENT;
            end
            for (int i = 0; i < CORES; i++) begin
                r_cthread[i] <= '0;
            end
            r_exit  <= 1'b0;
            r_stat  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_exit  <= n_exit;
            r_stat  <= n_stat;
            if (w_we) begin
                r_slot[w_waddr] <= w_wdata;
            end
            if (w_core_we) begin
                r_cthread[r_core] <= w_core_thread;
                r_busy[r_core]    <= w_core_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        if (r_state == S_IDLE && i_in_valid) begin
            r_func   <= i_func;
            r_core   <= i_core;
            r_thread <= i_thread;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status         <= r_stat;
            o_running_valid  <= r_busy[r_core] && (w_rdata == SL_RUNNING);
            o_running_thread <= (r_busy[r_core] && w_rdata == SL_RUNNING) ?
                                r_cthread[r_core] : '0;
            o_ready_count    <= r_count;
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(THREADS))
    `ASSERT_NEXT(a_idle_count_stable, i_clk, i_rst_n, r_state == S_IDLE, r_count == $past(r_count))
    `ASSERT_NEXT(a_pop_sets_busy, i_clk, i_rst_n, r_state == S_POP && r_count != '0, r_busy[r_core])

endmodule

/* tb/rrts_checker.sv */
// Checker for the round-robin thread scheduler: watches the request and result
// channels, predicts each result from its own scheduler state and compares.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_checker import rrts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [2:0]          i_func,
    input  logic [CORE_W-1:0]   i_core,
    input  logic [THREAD_W-1:0] i_thread,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [1:0]          i_status,
    input  logic [THREAD_W-1:0] i_running_thread,
    input  logic                i_running_valid,
    input  logic [CNT_W-1:0]    i_ready_count,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [1:0]          status;
        logic [THREAD_W-1:0] thread;
        logic                valid;
        logic [CNT_W-1:0]    count;
    } t_sched_result;

    t_slot               slot_state [THREADS];
    logic [THREAD_W-1:0] ready_fifo [$];
    logic [THREAD_W-1:0] core_thread [CORES];
    logic                core_busy [CORES];
    t_sched_result       expected_results [$];

    function automatic void unready(input logic [THREAD_W-1:0] t);
        foreach (ready_fifo[i]) begin
            if (ready_fifo[i] == t) begin
                ready_fifo.delete(i);
                return;
            end
        end
    endfunction

    function automatic t_status tick_core(input int c);
        logic [THREAD_W-1:0] h;
        if (core_busy[c] && slot_state[core_thread[c]] == SL_RUNNING) begin
            slot_state[core_thread[c]] = SL_READY;
            ready_fifo.push_back(core_thread[c]);
        end
        if (ready_fifo.size() == 0) return ST_EMPTY;
        h = ready_fifo.pop_front();
        slot_state[h] = SL_RUNNING;
        core_thread[c] = h;
        core_busy[c] = 1'b1;
        return ST_OK;
    endfunction

    function automatic t_sched_result schedule(input logic [2:0] f, input int c,
                                               input logic [THREAD_W-1:0] t);
        t_sched_result r;
        logic [THREAD_W-1:0] prev;
        t_status st;
        prev = core_thread[c];
        st = ST_INVALID;
        case (f)
            F_TICK: st = tick_core(c);
            F_PAUSE: begin
                if (core_busy[c] && slot_state[prev] == SL_RUNNING) begin
                    slot_state[prev] = SL_WAITING;
                    st = ST_OK;
                end
            end
            F_WAKE: begin
                if (slot_state[t] == SL_ABSENT) st = ST_ABSENT;
                else begin
                    if (slot_state[t] == SL_READY) unready(t);
                    slot_state[t] = SL_READY;
                    ready_fifo.push_back(t);
                    st = ST_OK;
                end
            end
            F_ADMIT: begin
                if (slot_state[t] == SL_ABSENT) begin
                    slot_state[t] = SL_READY;
                    ready_fifo.push_back(t);
                    st = ST_OK;
                end
            end
            F_EXIT: begin
                if (!core_busy[c]) st = ST_INVALID;
                else if (slot_state[prev] == SL_ABSENT) st = ST_ABSENT;
                else begin
                    st = tick_core(c);
                    if (st == ST_OK) begin
                        if (slot_state[prev] == SL_READY) unready(prev);
                        if (core_thread[c] == prev) core_busy[c] = 1'b0;
                        slot_state[prev] = SL_ABSENT;
                    end
                end
            end
            default: st = ST_INVALID;
        endcase
        r.status = st;
        r.valid = core_busy[c] && slot_state[core_thread[c]] == SL_RUNNING;
        r.thread = r.valid ? core_thread[c] : '0;
        r.count = CNT_W'(ready_fifo.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result got, exp_r;
        if (!i_rst_n) begin
            foreach (slot_state[i]) slot_state[i] = SL_ABSENT;
            foreach (core_thread[i]) begin
                core_thread[i] = '0;
                core_busy[i] = 1'b0;
            end
            ready_fifo.delete();
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(schedule(i_func, i_core, i_thread));
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_running_thread, i_running_valid, i_ready_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: status exp %0d act %0d, thread exp %0d act %0d, ",
                                 $time, exp_r.status, got.status, exp_r.thread, got.thread,
                                 "valid exp %0d act %0d, count exp %0d act %0d",
                                 exp_r.valid, got.valid, exp_r.count, got.count);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* tb/tb.sv */
// Top of the scheduler testbench: clock, reset, request stimulus and verdict.
// Depends on rrts_pkg, round_robin_thread_scheduler and rrts_checker.
`timescale 1ns / 1ps

module tb import rrts_pkg::*;;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          func = '0;
    logic [CORE_W-1:0]   core = '0;
    logic [THREAD_W-1:0] thread = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [THREAD_W-1:0] running_thread;
    logic                running_valid;
    logic [CNT_W-1:0]    ready_count;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    round_robin_thread_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_core(core), .i_thread(thread),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_running_thread(running_thread),
        .o_running_valid(running_valid), .o_ready_count(ready_count)
    );

    rrts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_core(core), .i_thread(thread),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_running_thread(running_thread),
        .i_running_valid(running_valid), .i_ready_count(ready_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("round_robin_thread_scheduler: mismatch");
            $finish;
        end
    end

    // Holds one beat until it is taken, after an optional random idle gap.
    // Valid drops only for an idle gap, so back-to-back beats keep it high.
    task automatic send_beat(input t_func f, input int c, input int t);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        func <= f;
        core <= CORE_W'(c);
        thread <= THREAD_W'(t);
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Ticks most often, then admits, exits, wakes, pauses and rare invalid codes.
    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)      send_beat(F_ADMIT, $urandom_range(3), $urandom_range(15));
        else if (pick < 50) send_beat(F_TICK, $urandom_range(3), $urandom_range(15));
        else if (pick < 62) send_beat(F_PAUSE, $urandom_range(3), $urandom_range(15));
        else if (pick < 77) send_beat(F_WAKE, $urandom_range(3), $urandom_range(15));
        else if (pick < 95) send_beat(F_EXIT, $urandom_range(3), $urandom_range(15));
        else                send_beat(t_func'($urandom_range(7, 5)), $urandom_range(3),
                                      $urandom_range(15));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue, idle cores, absent slots, rechosen exit, full queue, bad code.
        send_beat(F_TICK, 0, 0);
        send_beat(F_PAUSE, 1, 0);
        send_beat(F_EXIT, 2, 0);
        send_beat(F_WAKE, 3, 15);
        send_beat(F_ADMIT, 0, 0);
        send_beat(F_ADMIT, 0, 0);
        send_beat(F_EXIT, 3, 0);
        send_beat(F_TICK, 0, 0);
        send_beat(F_EXIT, 0, 0);
        send_beat(F_EXIT, 0, 0);
        for (int i = 0; i < 16; i++) send_beat(F_ADMIT, i % 4, 15 - i);
        send_beat(F_TICK, 3, 0);
        send_beat(F_WAKE, 3, 15);
        send_beat(F_WAKE, 1, 10);
        send_beat(F_PAUSE, 2, 0);
        send_beat(F_TICK, 1, 0);
        send_beat(F_PAUSE, 1, 0);
        send_beat(F_PAUSE, 1, 0);
        send_beat(t_func'(3'd7), 2, 5);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 51; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 51; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (170) random_beat();
        end
        in_valid <= 1'b0;

        send_idle_pct = 0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("round_robin_thread_scheduler: match");
        else
            $display("round_robin_thread_scheduler: mismatch");
        $finish;
    end

endmodule
